// ===== rtl/core/sal_pkg.sv =====
package sal_pkg;

	// ascii codes used on the line
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_COMMA = 8'h2C;
	localparam logic [7:0] ASCII_LF    = 8'h0A;

	// default sample width
	localparam int SAMPLE_BITS_DEF = 12;

	// number of register stages in the binary to bcd pipeline
	localparam int DD_STAGES = 4;

	// decimal digits needed for the largest value of a bits-wide sample
	function automatic int num_digits(input int bits);
		longint lim;
		longint p;
		int     n;
		lim = (longint'(1) << bits) - 1;
		p   = 10;
		n   = 1;
		while (p <= lim) begin
			p = p * 10;
			n = n + 1;
		end
		return n;
	endfunction

	// double dabble steps done in stage k, given steps per stage
	function automatic int stage_steps(input int bits, input int sps, input int k);
		int lo;
		int hi;
		lo = k * sps;
		hi = lo + sps;
		if (hi > bits) begin
			hi = bits;
		end
		if (lo >= bits) begin
			return 0;
		end
		return hi - lo;
	endfunction

endpackage

// ===== rtl/core/sample_to_ascii_line_top.sv =====
// sample to ascii line converter
//
// sample channel: sample_valid / sample_ready carry one unsigned sample of
// SAMPLE_BITS bits. char channel: char_valid / char_ready carry one ascii
// character per request in out_char; last_char marks the line feed.
// each sample becomes the line: lsb as '0' or '1', a comma, the value in
// decimal without leading zeros (a single '0' for zero), then a line feed.
//
// the first character of a line is valid once its sample has passed the
// four binary to bcd stages, then the line sequencer and its output
// register. throughput: one character per cycle while char_ready is high;
// a line has 3 plus its digit count characters, 4 to 7 at 12 bits, and
// the line sequencer's single character slot sets the rate. samples are
// taken every cycle into the bcd pipeline while it has room, so up to six
// samples can sit in flight, counting one whose line feed still waits in
// the output register.
// reset clears all valid bits and the sequencer; no sample is in flight.
// a stall on char_ready holds the output register, the sequencer and then
// the pipeline stage by stage; nothing is dropped or repeated.
module sample_to_ascii_line_top
	import sal_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   char_valid,
	input  logic                   char_ready,
	output logic [7:0]             out_char,
	output logic                   last_char
);

	localparam int NUM_DIGITS = num_digits(SAMPLE_BITS);
	localparam int DIG_W      = 4 * NUM_DIGITS;
	localparam int SPS        = (SAMPLE_BITS + DD_STAGES - 1) / DD_STAGES;

	logic                   st_valid [DD_STAGES+1];
	logic                   st_ready [DD_STAGES+1];
	logic [DIG_W-1:0]       st_bcd   [DD_STAGES+1];
	logic [SAMPLE_BITS-1:0] st_bin   [DD_STAGES+1];
	logic                   st_lsb   [DD_STAGES+1];

	// pipeline head
	assign st_valid[0]  = sample_valid;
	assign sample_ready = st_ready[0];
	assign st_bcd[0]    = '0;
	assign st_bin[0]    = sample;
	assign st_lsb[0]    = sample[0];

	// binary to bcd pipeline
	for (genvar k = 0; k < DD_STAGES; k++) begin : g_dd
		sal_dd_stage #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.NUM_DIGITS  (NUM_DIGITS),
			.STEPS       (stage_steps(SAMPLE_BITS, SPS, k))
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[k]),
			.in_ready  (st_ready[k]),
			.in_bcd    (st_bcd[k]),
			.in_bin    (st_bin[k]),
			.in_lsb    (st_lsb[k]),
			.out_valid (st_valid[k+1]),
			.out_ready (st_ready[k+1]),
			.out_bcd   (st_bcd[k+1]),
			.out_bin   (st_bin[k+1]),
			.out_lsb   (st_lsb[k+1])
		);
	end

	// line sequencer and output register
	sal_serializer #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st_valid[DD_STAGES]),
		.in_ready  (st_ready[DD_STAGES]),
		.in_bcd    (st_bcd[DD_STAGES]),
		.in_lsb    (st_lsb[DD_STAGES] ^ (|st_bin[DD_STAGES] & 1'b0)),
		.out_valid (char_valid),
		.out_ready (char_ready),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

// ===== rtl/core/sal_dd_stage.sv =====
module sal_dd_stage
	import sal_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int NUM_DIGITS  = num_digits(SAMPLE_BITS_DEF),
	parameter int STEPS       = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [4*NUM_DIGITS-1:0]   in_bcd,
	input  logic [SAMPLE_BITS-1:0]    in_bin,
	input  logic                      in_lsb,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [4*NUM_DIGITS-1:0]   out_bcd,
	output logic [SAMPLE_BITS-1:0]    out_bin,
	output logic                      out_lsb
);

	localparam int DIG_W = 4 * NUM_DIGITS;

	logic                   valid_s1;
	logic [DIG_W-1:0]       bcd_s1;
	logic [SAMPLE_BITS-1:0] bin_s1;
	logic                   lsb_s1;
	logic [DIG_W-1:0]       bcd_nxt;
	logic [SAMPLE_BITS-1:0] bin_nxt;

	// shift-add-3 steps for this slice of the conversion
	always_comb begin
		logic [DIG_W-1:0]       b;
		logic [SAMPLE_BITS-1:0] r;
		b = in_bcd;
		r = in_bin;
		for (int j = 0; j < STEPS; j++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[d*4 +: 4] >= 4'd5) begin
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
				end
			end
			b = {b[DIG_W-2:0], r[SAMPLE_BITS-1]};
			r = {r[SAMPLE_BITS-2:0], 1'b0};
		end
		bcd_nxt = b;
		bin_nxt = r;
	end

	// stage moves when empty or when the next stage takes its request
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bcd_s1 <= bcd_nxt;
			bin_s1 <= bin_nxt;
			lsb_s1 <= in_lsb;
		end
	end

	assign out_valid = valid_s1;
	assign out_bcd   = bcd_s1;
	assign out_bin   = bin_s1;
	assign out_lsb   = lsb_s1;

endmodule

// ===== rtl/core/sal_serializer.sv =====
module sal_serializer
	import sal_pkg::*;
#(
	parameter int NUM_DIGITS = num_digits(SAMPLE_BITS_DEF)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [4*NUM_DIGITS-1:0] in_bcd,
	input  logic                    in_lsb,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              out_char,
	output logic                    last_char
);

	localparam int DIG_W = 4 * NUM_DIGITS;
	localparam int IDX_W = $clog2(NUM_DIGITS);

	typedef enum logic [1:0] {
		PH_BIT,
		PH_COMMA,
		PH_DIGIT,
		PH_LF
	} phase_t;

	phase_t           phase_q;
	logic             busy_q;
	logic [IDX_W-1:0] dig_q;
	logic [DIG_W-1:0] bcd_q;
	logic             lsb_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             last_q;

	logic             out_load;
	logic             is_lf;
	logic [IDX_W-1:0] top_idx;
	logic [3:0]       digit;
	logic [7:0]       cur_char;

	// most significant nonzero digit, digit zero for a zero sample
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (in_bcd[d*4 +: 4] != 4'd0) begin
				top_idx = IDX_W'(d);
			end
		end
	end

	assign digit = bcd_q[dig_q*4 +: 4];

	// character for the current position of the line
	always_comb begin
		case (phase_q)
			PH_BIT:   cur_char = ASCII_ZERO | {7'b0, lsb_q};
			PH_COMMA: cur_char = ASCII_COMMA;
			PH_DIGIT: cur_char = ASCII_ZERO + {4'b0, digit};
			PH_LF:    cur_char = ASCII_LF;
			default:  cur_char = ASCII_LF;
		endcase
	end

	assign is_lf    = (phase_q == PH_LF);
	assign out_load = busy_q && (!out_valid_q || out_ready);
	// next line may load on the cycle its predecessor's line feed leaves
	assign in_ready = !busy_q || (out_load && is_lf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_BIT;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_char_q  <= cur_char;
				last_q      <= is_lf;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// line sequencer
			if (in_valid && in_ready) begin
				busy_q  <= 1'b1;
				phase_q <= PH_BIT;
				dig_q   <= top_idx;
			end else if (out_load) begin
				case (phase_q)
					PH_BIT:   phase_q <= PH_COMMA;
					PH_COMMA: phase_q <= PH_DIGIT;
					PH_DIGIT: begin
						if (dig_q == '0) begin
							phase_q <= PH_LF;
						end else begin
							dig_q <= dig_q - 1'b1;
						end
					end
					PH_LF:    busy_q <= 1'b0;
					default:  busy_q <= 1'b0;
				endcase
			end
		end
	end

	// line payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bcd_q <= in_bcd;
			lsb_q <= in_lsb;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule

// ===== rtl/core/sal_checker.sv =====
module sal_checker
	import sal_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       char_valid,
	input logic       char_ready,
	input logic [7:0] out_char,
	input logic       last_char
);

	logic       char_acc;
	logic [3:0] pos_q;

	assign char_acc = char_valid && char_ready;

	// position of the next character within its line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (char_acc) begin
			if (last_char) begin
				pos_q <= '0;
			end else if (pos_q != 4'hF) begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=>
			char_valid && $stable(out_char) && $stable(last_char))
		else $error("char request changed while stalled");

	// a line opens with the lsb digit
	a_bit: assert property (@(posedge clk) disable iff (!arst_n)
		char_acc && pos_q == 4'd0 |->
			!last_char && (out_char == ASCII_ZERO || out_char == ASCII_ZERO + 8'd1))
		else $error("line does not open with a bit digit");

	// then a comma
	a_comma: assert property (@(posedge clk) disable iff (!arst_n)
		char_acc && pos_q == 4'd1 |-> !last_char && out_char == ASCII_COMMA)
		else $error("comma missing after bit digit");

	// decimal part holds only digits
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		char_acc && pos_q >= 4'd2 && !last_char |->
			out_char >= ASCII_ZERO && out_char <= ASCII_NINE)
		else $error("non-digit in decimal part");

	// line feed closes a line with at least one digit
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_acc && last_char |-> pos_q >= 4'd3 && out_char == ASCII_LF)
		else $error("bad line end");

endmodule

bind sample_to_ascii_line_top sal_checker u_sal_checker (.*);

// ===== tb/tb_sample_to_ascii_line_top.sv =====
module tb_sample_to_ascii_line_top;
	import sal_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W        = SAMPLE_BITS_DEF;
	localparam int NUM_RANDOM   = 80;
	localparam int CALM_TAIL    = 20;
	localparam int LONG_HOLD_AT = 40;
	localparam int LONG_HOLD    = 80;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} line_char_t;

	logic             clk;
	logic             arst_n;
	logic             sample_valid;
	logic             sample_ready;
	logic [SMP_W-1:0] sample;
	logic             char_valid;
	logic             char_ready;
	logic [7:0]       out_char;
	logic             last_char;

	// samples waiting to be offered and characters still owed by the block
	logic [SMP_W-1:0] pending_samples[$];
	line_char_t       line_chars_q[$];

	logic sample_fire;
	logic quiet;
	int   samples_taken;
	int   chars_checked;
	int   lines_done;
	int   mismatches;
	int   idle_cycles;
	int   src_gap;
	int   sink_gap;
	int   long_hold;
	bit   long_done;
	bit   saw_width[8];

	sample_to_ascii_line_top #(
		.SAMPLE_BITS(SMP_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.out_char    (out_char),
		.last_char   (last_char)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_char(input logic [7:0] ch, input logic last);
		line_char_t c;
		c.ch   = ch;
		c.last = last;
		line_chars_q.push_back(c);
	endfunction

	// expected line: lsb digit, comma, decimal without leading zeros, line feed
	function automatic void predict_line(input logic [SMP_W-1:0] s);
		int unsigned v;
		int          nd;
		logic [3:0]  dig[12];
		v  = 32'(s);
		nd = 0;
		push_char(ASCII_ZERO + {7'd0, s[0]}, 1'b0);
		push_char(ASCII_COMMA, 1'b0);
		do begin
			dig[nd] = 4'(v % 10);
			nd      = nd + 1;
			v       = v / 10;
		end while (v != 0);
		for (int i = nd - 1; i >= 0; i--) begin
			push_char(ASCII_ZERO + {4'd0, dig[i]}, 1'b0);
		end
		push_char(ASCII_LF, 1'b1);
		saw_width[nd + 3] = 1'b1;
	endfunction

	// sample request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_fire) begin
			if (sample_fire && !quiet && $urandom_range(0, 3) == 0) begin
				src_gap = $urandom_range(1, 10);
			end
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
				sample_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				sample       <= pending_samples.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// char request receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			char_ready <= 1'b0;
		end else if (long_hold > 0) begin
			long_hold = long_hold - 1;
			char_ready <= 1'b0;
		end else if (!long_done && samples_taken >= LONG_HOLD_AT) begin
			long_done = 1'b1;
			long_hold = LONG_HOLD - 1;
			char_ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap = sink_gap - 1;
			char_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(1, 10) - 1;
			char_ready <= 1'b0;
		end else begin
			char_ready <= 1'b1;
		end
	end

	// monitor: predict on sample requests, check char requests, watchdog
	always @(posedge clk) begin
		sample_fire <= arst_n && sample_valid && sample_ready;
		quiet       <= pending_samples.size() <= CALM_TAIL;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				predict_line(sample);
				samples_taken <= samples_taken + 1;
			end
			if (char_valid && char_ready) begin
				if (line_chars_q.size() == 0) begin
					$display("%0t: unexpected char out_char=0x%02h last_char=%b",
						$time, out_char, last_char);
					mismatches = mismatches + 1;
				end else begin
					line_char_t exp_c;
					exp_c = line_chars_q.pop_front();
					if (out_char !== exp_c.ch) begin
						$display("%0t: out_char expected 0x%02h actual 0x%02h",
							$time, exp_c.ch, out_char);
						mismatches = mismatches + 1;
					end
					if (last_char !== exp_c.last) begin
						$display("%0t: last_char expected %b actual %b",
							$time, exp_c.last, last_char);
						mismatches = mismatches + 1;
					end
					if (exp_c.last) begin
						lines_done = lines_done + 1;
					end
				end
				chars_checked = chars_checked + 1;
			end
			if ((sample_valid && sample_ready) || (char_valid && char_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles = idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
				$display("FAIL sample_to_ascii_line_top");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [SMP_W-1:0] directed[$];
		int               widths_seen;
		arst_n        = 1'b0;
		sample_valid  = 1'b0;
		sample        = '0;
		char_ready    = 1'b0;
		sample_fire   = 1'b0;
		quiet         = 1'b0;
		samples_taken = 0;
		chars_checked = 0;
		lines_done    = 0;
		mismatches    = 0;
		idle_cycles   = 0;
		src_gap       = 0;
		sink_gap      = 0;
		long_hold     = 0;
		long_done     = 1'b0;

		// zero, extremes, digit count boundaries, alternating bit patterns
		directed = '{12'd0, 12'd1, 12'd4095, 12'd4094, 12'd9, 12'd10, 12'd99,
			12'd100, 12'd999, 12'd1000, 12'd1023, 12'd1024, 12'd2048, 12'hAAA,
			12'h555, 12'd7, 12'd8, 12'd11, 12'd101, 12'd1001, 12'd4000};
		foreach (directed[i]) begin
			pending_samples.push_back(directed[i]);
		end
		// random part spread over every digit count
		for (int i = 0; i < NUM_RANDOM; i++) begin
			case ($urandom_range(0, 4))
				0: pending_samples.push_back(SMP_W'($urandom_range(0, 9)));
				1: pending_samples.push_back(SMP_W'($urandom_range(10, 99)));
				2: pending_samples.push_back(SMP_W'($urandom_range(100, 999)));
				3: pending_samples.push_back(SMP_W'($urandom_range(1000, 4095)));
				default: pending_samples.push_back(SMP_W'($urandom));
			endcase
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_samples.size() > 0 || sample_valid) begin
			@(posedge clk);
		end
		while (line_chars_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		widths_seen = 0;
		foreach (saw_width[i]) begin
			if (saw_width[i]) begin
				widths_seen = widths_seen + 1;
			end
		end
		$display("converted %0d samples into %0d checked characters over %0d lines,",
			samples_taken, chars_checked, lines_done);
		$display("%0d distinct line lengths, one long output stall, %0d mismatches",
			widths_seen, mismatches);
		if (mismatches == 0) begin
			$display("PASS sample_to_ascii_line_top");
		end else begin
			$display("FAIL sample_to_ascii_line_top");
		end
		$finish;
	end

endmodule
